[rtl/mtse_pkg.sv]
// Package for the multitouch slot event encoder.
// Holds sizes, command and event codes, and the job record passed from front to back.
// No dependencies.
package mtse_pkg;

    localparam int SLOT_COUNT  = 10;
    localparam int SLOT_W      = 4;
    localparam int CNT_W       = $clog2(SLOT_COUNT + 1);
    localparam int TID_W       = 31;
    localparam int POS_W       = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [TID_W-1:0] TID_MAX = '1;
    localparam logic [TID_W-1:0] TID_ONE = TID_W'(1);

    localparam logic signed [POS_W-1:0] DEF_LOW  = 16'sd0;
    localparam logic signed [POS_W-1:0] DEF_HIGH = 16'sd4095;
    localparam logic signed [POS_W-1:0] NORM_MAX = 16'sd1000;

    // floor(p / 1000) for p below 2**26 as (p * DIV_RECIP) >> DIV_SHIFT
    localparam int PROD_W    = 26;
    localparam int DIV_SHIFT = 36;
    localparam int RECIP_W   = 27;
    localparam logic [RECIP_W-1:0] DIV_RECIP =
        RECIP_W'(((64'd1 << DIV_SHIFT) / 64'd1000) + 64'd1);

    localparam logic       CMD_POINT   = 1'b0;
    localparam logic       CMD_RELEASE = 1'b1;

    localparam logic [1:0] ACT_DOWN = 2'd0;
    localparam logic [1:0] ACT_MOVE = 2'd1;
    localparam logic [1:0] ACT_UP   = 2'd2;
    localparam logic [1:0] ACT_NONE = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_X_LOW    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_X_HIGH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_Y_LOW    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_Y_HIGH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIRROR_X = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MIRROR_Y = 3'd5;

    localparam logic [1:0] KIND_REL  = 2'd0;
    localparam logic [1:0] KIND_UP   = 2'd1;
    localparam logic [1:0] KIND_DOWN = 2'd2;
    localparam logic [1:0] KIND_MOVE = 2'd3;

    localparam logic [1:0] EV_SYN = 2'd0;
    localparam logic [1:0] EV_KEY = 2'd1;
    localparam logic [1:0] EV_ABS = 2'd3;

    localparam logic [8:0] CODE_ABS_X  = 9'd0;
    localparam logic [8:0] CODE_ABS_Y  = 9'd1;
    localparam logic [8:0] CODE_SYNC   = 9'd0;
    localparam logic [8:0] CODE_SLOT   = 9'd47;
    localparam logic [8:0] CODE_MT_X   = 9'd53;
    localparam logic [8:0] CODE_MT_Y   = 9'd54;
    localparam logic [8:0] CODE_TRACK  = 9'd57;
    localparam logic [8:0] CODE_TOOL   = 9'd325;
    localparam logic [8:0] CODE_TOUCH  = 9'd330;

    localparam logic [31:0] VAL_RELEASE = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [1:0]              kind;
        logic [SLOT_W-1:0]       slot;
        logic [TID_W-1:0]        tid;
        logic signed [POS_W-1:0] mx;
        logic signed [POS_W-1:0] my;
        logic                    mirror_x;
        logic                    mirror_y;
        logic                    keys;
        logic [SLOT_COUNT-1:0]   mask;
    } t_job;

endpackage

[rtl/mtse_if.sv]
// Channel interfaces: touch input, configuration write, event output.
// Depends on mtse_pkg.
interface mtse_in_if;
    import mtse_pkg::*;
    logic                    valid;
    logic                    ready;
    logic                    cmd;
    logic [SLOT_W-1:0]       slot;
    logic [1:0]              action;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    modport source (output valid, cmd, slot, action, pos_x, pos_y, input ready);
    modport sink   (input valid, cmd, slot, action, pos_x, pos_y, output ready);
endinterface

interface mtse_cfg_if;
    import mtse_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

interface mtse_ev_if;
    logic               valid;
    logic               ready;
    logic [1:0]         ev_type;
    logic [8:0]         ev_code;
    logic signed [31:0] ev_value;
    logic               last;
    modport source (output valid, ev_type, ev_code, ev_value, last, input ready);
    modport sink   (input valid, ev_type, ev_code, ev_value, last, output ready);
endinterface

[rtl/multitouch_slot_event_encoder_unit.sv]
// Top level of the multitouch slot event encoder: front end, job queue, event sequencer.
// Depends on mtse_pkg, mtse_if, mtse_front, mtse_queue, mtse_back.
//
//   channel   dir  modport  payload
//   i_touch   in   sink     cmd, slot, action, pos_x, pos_y
//   i_cfg     in   sink     index, data (always ready)
//   o_event   out  source   ev_type, ev_code, ev_value, last
//
// Front end: each touch item passes accept, scale multiply, reciprocal multiply and push;
// the input is not ready again until the push, but a dropped item leaves it ready.
// Sequencer: pops a job, then walks its event steps (mirror steps are visited even when off);
// a release-all scans the slots in order, emitting slot and tracking release for each active one.
// Reset clears slot flags, touch count and the id allocator at once; no clearing pass.
// A stalled o_event holds the sequencer; the two-entry queue then holds the front end.
module multitouch_slot_event_encoder_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mtse_in_if.sink   i_touch,
    mtse_cfg_if.sink  i_cfg,
    mtse_ev_if.source o_event
);
    import mtse_pkg::*;

    logic push, pop, full, empty;
    t_job push_job, pop_job;

    mtse_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_touch (i_touch),
        .i_cfg   (i_cfg),
        .o_push  (push),
        .o_job   (push_job),
        .i_full  (full)
    );

    mtse_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_job   (pop_job),
        .o_empty (empty)
    );

    mtse_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (pop_job),
        .i_empty (empty),
        .o_pop   (pop),
        .o_event (o_event)
    );

endmodule

[rtl/mtse_front.sv]
// Front end: configuration registers, slot state, classification and coordinate mapping.
// Depends on mtse_pkg and mtse_if; pushes one job per event run into the queue.
module mtse_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    mtse_in_if.sink        i_touch,
    mtse_cfg_if.sink       i_cfg,
    output logic           o_push,
    output mtse_pkg::t_job o_job,
    input  logic           i_full
);
    import mtse_pkg::*;

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_MUL  = 2'd1;
    localparam logic [1:0] F_DIV  = 2'd2;
    localparam logic [1:0] F_PUSH = 2'd3;

    logic [1:0]              r_state, n_state;
    logic signed [POS_W-1:0] r_x_low, r_x_high, r_y_low, r_y_high;
    logic                    r_mirror_x, r_mirror_y;
    logic [SLOT_COUNT-1:0]   r_active, n_active;
    logic [TID_W-1:0]        r_tid [SLOT_COUNT];
    logic [CNT_W-1:0]        r_count, n_count;
    logic [TID_W-1:0]        r_next_tid, n_next_tid;
    t_job                    r_job, n_job;
    logic signed [POS_W-1:0] r_px, r_py;
    logic                    r_scale_x, r_scale_y;
    logic [PROD_W-1:0]       r_prod_x, r_prod_y;
    logic [POS_W-1:0]        r_q_x, r_q_y;

    logic                    accept, job_valid, cur_active, in_range, tid_write;
    logic [1:0]              eff_action;
    logic [TID_W-1:0]        tid_new;
    logic [CNT_W-1:0]        cnt_dec;
    logic signed [POS_W-1:0] lo_x, hi_x, lo_y, hi_y;
    logic [POS_W-1:0]        span_x, span_y;

    function automatic logic signed [POS_W-1:0] clamp_axis(
        input logic signed [POS_W-1:0] v,
        input logic signed [POS_W-1:0] lo,
        input logic signed [POS_W-1:0] hi,
        input logic                    scale,
        input logic [POS_W-1:0]        q
    );
        logic signed [POS_W:0] r;
        logic signed [POS_W:0] lo17;
        logic signed [POS_W:0] hi17;
        lo17 = {lo[POS_W-1], lo};
        hi17 = {hi[POS_W-1], hi};
        if (scale) begin
            r = lo17 + $signed({1'b0, q});
        end else begin
            r = {v[POS_W-1], v};
        end
        if (r < lo17) begin
            r = lo17;
        end
        if (r > hi17) begin
            r = hi17;
        end
        return r[POS_W-1:0];
    endfunction

    assign i_cfg.ready   = 1'b1;
    assign i_touch.ready = (r_state == F_IDLE);
    assign accept        = i_touch.valid && i_touch.ready;

    always_comb begin
        if (r_x_high <= r_x_low) begin
            lo_x = DEF_LOW;
            hi_x = DEF_HIGH;
        end else begin
            lo_x = r_x_low;
            hi_x = r_x_high;
        end
        if (r_y_high <= r_y_low) begin
            lo_y = DEF_LOW;
            hi_y = DEF_HIGH;
        end else begin
            lo_y = r_y_low;
            hi_y = r_y_high;
        end
        span_x = hi_x - lo_x;
        span_y = hi_y - lo_y;
    end

    always_comb begin
        n_active   = r_active;
        n_count    = r_count;
        n_next_tid = r_next_tid;
        n_job      = r_job;
        job_valid  = 1'b0;
        tid_write  = 1'b0;
        tid_new    = (r_next_tid == '0) ? TID_ONE : r_next_tid;
        cnt_dec    = (r_count != '0) ? r_count - CNT_W'(1) : r_count;
        in_range   = {1'b0, i_touch.slot} < (SLOT_W + 1)'(SLOT_COUNT);
        cur_active = in_range && r_active[i_touch.slot];
        eff_action = (i_touch.action == ACT_MOVE && !cur_active) ? ACT_DOWN : i_touch.action;

        n_job.slot     = i_touch.slot;
        n_job.mirror_x = r_mirror_x;
        n_job.mirror_y = r_mirror_y;
        n_job.mask     = r_active;
        n_job.keys     = 1'b1;
        n_job.kind     = KIND_REL;

        if (i_touch.cmd == CMD_RELEASE) begin
            if (r_active != '0) begin
                job_valid = 1'b1;
                n_active  = '0;
                n_count   = '0;
            end
        end else if (in_range && i_touch.action != ACT_NONE) begin
            case (eff_action)
                ACT_UP: begin
                    if (cur_active) begin
                        job_valid                = 1'b1;
                        n_job.kind               = KIND_UP;
                        n_job.keys               = (cnt_dec == '0);
                        n_active[i_touch.slot]   = 1'b0;
                        n_count                  = cnt_dec;
                    end
                end
                ACT_DOWN: begin
                    job_valid  = 1'b1;
                    n_job.kind = KIND_DOWN;
                    n_job.keys = (r_count == '0);
                    if (!cur_active) begin
                        tid_write              = 1'b1;
                        n_job.tid              = tid_new;
                        n_active[i_touch.slot] = 1'b1;
                        n_count                = r_count + CNT_W'(1);
                        n_next_tid             = (tid_new == TID_MAX) ? TID_ONE
                                                                      : tid_new + TID_ONE;
                    end else begin
                        n_job.tid = r_tid[i_touch.slot];
                    end
                end
                default: begin
                    job_valid  = 1'b1;
                    n_job.kind = KIND_MOVE;
                    n_job.keys = 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE: begin
                if (accept && job_valid) begin
                    n_state = F_MUL;
                end
            end
            F_MUL:  n_state = F_DIV;
            F_DIV:  n_state = F_PUSH;
            F_PUSH: begin
                if (!i_full) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_comb begin
        o_job    = r_job;
        o_job.mx = clamp_axis(r_px, lo_x, hi_x, r_scale_x, r_q_x);
        o_job.my = clamp_axis(r_py, lo_y, hi_y, r_scale_y, r_q_y);
    end

    assign o_push = (r_state == F_PUSH) && !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= F_IDLE;
            r_x_low    <= DEF_LOW;
            r_x_high   <= DEF_HIGH;
            r_y_low    <= DEF_LOW;
            r_y_high   <= DEF_HIGH;
            r_mirror_x <= 1'b0;
            r_mirror_y <= 1'b0;
            r_active   <= '0;
            r_count    <= '0;
            r_next_tid <= TID_ONE;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    REG_X_LOW:    r_x_low    <= i_cfg.data;
                    REG_X_HIGH:   r_x_high   <= i_cfg.data;
                    REG_Y_LOW:    r_y_low    <= i_cfg.data;
                    REG_Y_HIGH:   r_y_high   <= i_cfg.data;
                    REG_MIRROR_X: r_mirror_x <= i_cfg.data[0];
                    REG_MIRROR_Y: r_mirror_y <= i_cfg.data[0];
                    default: ;
                endcase
            end
            if (accept) begin
                r_active   <= n_active;
                r_count    <= n_count;
                r_next_tid <= n_next_tid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && tid_write) begin
            r_tid[i_touch.slot] <= tid_new;
        end
        if (accept) begin
            r_job <= n_job;
            r_px  <= i_touch.pos_x;
            r_py  <= i_touch.pos_y;
        end
        if (r_state == F_MUL) begin
            r_scale_x <= (hi_x > NORM_MAX) && (r_px >= 16'sd0) && (r_px <= NORM_MAX);
            r_scale_y <= (hi_y > NORM_MAX) && (r_py >= 16'sd0) && (r_py <= NORM_MAX);
            r_prod_x  <= PROD_W'(r_px[9:0]) * PROD_W'(span_x);
            r_prod_y  <= PROD_W'(r_py[9:0]) * PROD_W'(span_y);
        end
        if (r_state == F_DIV) begin
            r_q_x <= POS_W'((53'(r_prod_x) * 53'(DIV_RECIP)) >> DIV_SHIFT);
            r_q_y <= POS_W'((53'(r_prod_y) * 53'(DIV_RECIP)) >> DIV_SHIFT);
        end
    end

`ifndef SYNTH
    a_count_matches_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'($countones(r_active)) == 32'(r_count))
        else $error("touch count differs from active slot count");

    a_next_tid_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next_tid != '0)
        else $error("tracking id allocator reached zero");
`endif

endmodule

[rtl/mtse_queue.sv]
// Short job queue between the front end and the event sequencer.
// Depends on mtse_pkg.
module mtse_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mtse_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output mtse_pkg::t_job o_job,
    output logic           o_empty
);
    import mtse_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    t_job              r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr, r_rd;
    logic [QCNT_W-1:0] r_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && o_full) |-> i_pop)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty queue");
`endif

endmodule

[rtl/mtse_back.sv]
// Event sequencer: expands one job into its protocol-B event run.
// Depends on mtse_pkg and mtse_if; registered event output.
module mtse_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  mtse_pkg::t_job i_job,
    input  logic           i_empty,
    output logic           o_pop,
    mtse_ev_if.source      o_event
);
    import mtse_pkg::*;

    localparam logic [3:0] B_IDLE  = 4'd0;
    localparam logic [3:0] B_SCAN  = 4'd1;
    localparam logic [3:0] B_RTRK  = 4'd2;
    localparam logic [3:0] B_SLOT  = 4'd3;
    localparam logic [3:0] B_TRACK = 4'd4;
    localparam logic [3:0] B_MTX   = 4'd5;
    localparam logic [3:0] B_MTY   = 4'd6;
    localparam logic [3:0] B_ABSX  = 4'd7;
    localparam logic [3:0] B_ABSY  = 4'd8;
    localparam logic [3:0] B_TOOL  = 4'd9;
    localparam logic [3:0] B_TOUCH = 4'd10;
    localparam logic [3:0] B_SYNC  = 4'd11;

    localparam logic [SLOT_W-1:0] IDX_LAST = SLOT_W'(SLOT_COUNT - 1);

    logic [3:0]        r_step, n_step;
    logic [SLOT_W-1:0] r_idx, n_idx;
    t_job              r_job, n_job;
    logic              r_ov;
    logic [1:0]        r_type;
    logic [8:0]        r_code;
    logic [31:0]       r_value;
    logic              r_last;

    logic              adv, emit, ev_last;
    logic [1:0]        ev_type;
    logic [8:0]        ev_code;
    logic [31:0]       ev_value;
    logic [31:0]       key_value;

    assign adv       = !r_ov || o_event.ready;
    assign key_value = (r_job.kind == KIND_DOWN) ? 32'd1 : 32'd0;

    always_comb begin
        n_step   = r_step;
        n_idx    = r_idx;
        n_job    = r_job;
        o_pop    = 1'b0;
        emit     = 1'b0;
        ev_type  = EV_ABS;
        ev_code  = CODE_SLOT;
        ev_value = '0;
        ev_last  = 1'b0;
        if (adv) begin
            case (r_step)
                B_IDLE: begin
                    if (!i_empty) begin
                        o_pop  = 1'b1;
                        n_job  = i_job;
                        n_idx  = '0;
                        n_step = (i_job.kind == KIND_REL) ? B_SCAN : B_SLOT;
                    end
                end
                B_SCAN: begin
                    if (r_job.mask[r_idx]) begin
                        emit     = 1'b1;
                        ev_value = 32'(r_idx);
                        n_step   = B_RTRK;
                    end else if (r_idx == IDX_LAST) begin
                        n_step = B_TOOL;
                    end else begin
                        n_idx = r_idx + SLOT_W'(1);
                    end
                end
                B_RTRK: begin
                    emit     = 1'b1;
                    ev_code  = CODE_TRACK;
                    ev_value = VAL_RELEASE;
                    if (r_idx == IDX_LAST) begin
                        n_step = B_TOOL;
                    end else begin
                        n_idx  = r_idx + SLOT_W'(1);
                        n_step = B_SCAN;
                    end
                end
                B_SLOT: begin
                    emit     = 1'b1;
                    ev_value = 32'(r_job.slot);
                    n_step   = (r_job.kind == KIND_MOVE) ? B_MTX : B_TRACK;
                end
                B_TRACK: begin
                    emit    = 1'b1;
                    ev_code = CODE_TRACK;
                    if (r_job.kind == KIND_UP) begin
                        ev_value = VAL_RELEASE;
                        n_step   = r_job.keys ? B_TOOL : B_SYNC;
                    end else begin
                        ev_value = {1'b0, r_job.tid};
                        n_step   = B_MTX;
                    end
                end
                B_MTX: begin
                    emit     = 1'b1;
                    ev_code  = CODE_MT_X;
                    ev_value = 32'(r_job.mx);
                    n_step   = B_MTY;
                end
                B_MTY: begin
                    emit     = 1'b1;
                    ev_code  = CODE_MT_Y;
                    ev_value = 32'(r_job.my);
                    n_step   = B_ABSX;
                end
                B_ABSX: begin
                    emit     = r_job.mirror_x;
                    ev_code  = CODE_ABS_X;
                    ev_value = 32'(r_job.mx);
                    n_step   = B_ABSY;
                end
                B_ABSY: begin
                    emit     = r_job.mirror_y;
                    ev_code  = CODE_ABS_Y;
                    ev_value = 32'(r_job.my);
                    n_step   = (r_job.kind == KIND_DOWN && r_job.keys) ? B_TOOL : B_SYNC;
                end
                B_TOOL: begin
                    emit     = 1'b1;
                    ev_type  = EV_KEY;
                    ev_code  = CODE_TOOL;
                    ev_value = key_value;
                    n_step   = B_TOUCH;
                end
                B_TOUCH: begin
                    emit     = 1'b1;
                    ev_type  = EV_KEY;
                    ev_code  = CODE_TOUCH;
                    ev_value = key_value;
                    n_step   = B_SYNC;
                end
                B_SYNC: begin
                    emit    = 1'b1;
                    ev_type = EV_SYN;
                    ev_code = CODE_SYNC;
                    ev_last = 1'b1;
                    n_step  = B_IDLE;
                end
                default: n_step = B_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= B_IDLE;
            r_ov   <= 1'b0;
        end else begin
            r_step <= n_step;
            if (adv) begin
                r_ov <= emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_job <= n_job;
        if (adv && emit) begin
            r_type  <= ev_type;
            r_code  <= ev_code;
            r_value <= ev_value;
            r_last  <= ev_last;
        end
    end

    assign o_event.valid    = r_ov;
    assign o_event.ev_type  = r_type;
    assign o_event.ev_code  = r_code;
    assign o_event.ev_value = r_value;
    assign o_event.last     = r_last;

`ifndef SYNTH
    a_last_is_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_event.valid && o_event.last) |-> (o_event.ev_type == EV_SYN
                                             && o_event.ev_value == 32'sd0))
        else $error("run closed by an event other than sync");

    a_release_has_slots: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == B_SCAN || r_step == B_RTRK) |-> (r_job.kind == KIND_REL
                                                    && r_job.mask != '0))
        else $error("release scan on a job without active slots");
`endif

endmodule

[bench/testbench.sv]
// Self-checking bench for multitouch_slot_event_encoder_unit: sends touch items and register
// writes, predicts each protocol-B event run and compares it with the event channel.
// Depends on mtse_pkg, mtse_if and the encoder RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import mtse_pkg::*;

    localparam int LIMIT_CYCLES  = 1_000_000;
    localparam int SETTLE_CYCLES = 80;
    localparam int REPORT_MAX    = 10;
    localparam int PHASE_ITEMS   = 50;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    localparam logic [31:0] KEY_UP   = 32'd0;
    localparam logic [31:0] KEY_DOWN = 32'd1;

    typedef struct {
        logic                    cmd;
        logic [SLOT_W-1:0]       slot;
        logic [1:0]              action;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
    } t_touch;

    typedef struct {
        logic [1:0]  ev_type;
        logic [8:0]  ev_code;
        logic [31:0] ev_value;
        logic        last;
    } t_ev;

    typedef enum {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_BURSTY} t_rx_mode;

    class t_slot_event_board;
        t_ev                     expected_q[$];
        logic                    slot_on[SLOT_COUNT];
        logic [TID_W-1:0]        slot_tid[SLOT_COUNT];
        int                      active_cnt;
        logic [TID_W-1:0]        next_tid;
        logic signed [POS_W-1:0] x_lo, x_hi, y_lo, y_hi;
        logic                    mir_x, mir_y;
        int                      mismatches, events_checked, items_noted;
        int                      peak_active, longest_run;

        function new();
            foreach (slot_on[i]) begin
                slot_on[i]  = 1'b0;
                slot_tid[i] = '0;
            end
            active_cnt = 0;
            next_tid   = TID_ONE;
            x_lo = DEF_LOW;
            x_hi = DEF_HIGH;
            y_lo = DEF_LOW;
            y_hi = DEF_HIGH;
            mir_x = 1'b0;
            mir_y = 1'b0;
            mismatches = 0;
            events_checked = 0;
            items_noted = 0;
            peak_active = 0;
            longest_run = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_X_LOW:    x_lo  = data;
                REG_X_HIGH:   x_hi  = data;
                REG_Y_LOW:    y_lo  = data;
                REG_Y_HIGH:   y_hi  = data;
                REG_MIRROR_X: mir_x = data[0];
                REG_MIRROR_Y: mir_y = data[0];
                default: ;
            endcase
        endfunction

        function int map_axis(input logic signed [POS_W-1:0] v,
                              input logic signed [POS_W-1:0] lo_r,
                              input logic signed [POS_W-1:0] hi_r);
            int lo, hi, r;
            lo = lo_r;
            hi = hi_r;
            if (hi <= lo) begin
                lo = 0;
                hi = 4095;
            end
            r = v;
            if (hi > 1000 && r >= 0 && r <= 1000) r = lo + (r * (hi - lo)) / 1000;
            if (r < lo) r = lo;
            if (r > hi) r = hi;
            return r;
        endfunction

        function void add(logic [1:0] t, logic [8:0] c, logic [31:0] v, logic l);
            t_ev e;
            e.ev_type  = t;
            e.ev_code  = c;
            e.ev_value = v;
            e.last     = l;
            expected_q.push_back(e);
        endfunction

        function void note_touch(t_touch t);
            int       start_n, run_n, mx, my;
            logic     keys, any;
            logic [1:0] act;
            start_n = expected_q.size();
            items_noted++;
            any  = 1'b0;
            keys = 1'b0;
            act  = t.action;
            if (t.cmd == CMD_RELEASE) begin
                for (int i = 0; i < SLOT_COUNT; i++) begin
                    if (slot_on[i]) begin
                        add(EV_ABS, CODE_SLOT, i, 1'b0);
                        add(EV_ABS, CODE_TRACK, VAL_RELEASE, 1'b0);
                        slot_on[i] = 1'b0;
                        any = 1'b1;
                    end
                end
                if (any) begin
                    active_cnt = 0;
                    add(EV_KEY, CODE_TOOL, KEY_UP, 1'b0);
                    add(EV_KEY, CODE_TOUCH, KEY_UP, 1'b0);
                    add(EV_SYN, CODE_SYNC, 32'd0, 1'b1);
                end
            end else if (t.slot < SLOT_COUNT && act != ACT_NONE) begin
                if (act == ACT_MOVE && !slot_on[t.slot]) act = ACT_DOWN;
                if (act == ACT_UP) begin
                    if (slot_on[t.slot]) begin
                        add(EV_ABS, CODE_SLOT, 32'(t.slot), 1'b0);
                        add(EV_ABS, CODE_TRACK, VAL_RELEASE, 1'b0);
                        slot_on[t.slot] = 1'b0;
                        if (active_cnt > 0) active_cnt--;
                        if (active_cnt == 0) begin
                            add(EV_KEY, CODE_TOOL, KEY_UP, 1'b0);
                            add(EV_KEY, CODE_TOUCH, KEY_UP, 1'b0);
                        end
                        add(EV_SYN, CODE_SYNC, 32'd0, 1'b1);
                    end
                end else begin
                    mx = map_axis(t.pos_x, x_lo, x_hi);
                    my = map_axis(t.pos_y, y_lo, y_hi);
                    add(EV_ABS, CODE_SLOT, 32'(t.slot), 1'b0);
                    if (act == ACT_DOWN) begin
                        keys = (active_cnt == 0);
                        if (!slot_on[t.slot]) begin
                            slot_on[t.slot] = 1'b1;
                            if (next_tid == '0) next_tid = TID_ONE;
                            slot_tid[t.slot] = next_tid;
                            next_tid++;
                            if (next_tid == '0) next_tid = TID_ONE;
                            active_cnt++;
                        end
                        add(EV_ABS, CODE_TRACK, {1'b0, slot_tid[t.slot]}, 1'b0);
                    end
                    add(EV_ABS, CODE_MT_X, mx, 1'b0);
                    add(EV_ABS, CODE_MT_Y, my, 1'b0);
                    if (mir_x) add(EV_ABS, CODE_ABS_X, mx, 1'b0);
                    if (mir_y) add(EV_ABS, CODE_ABS_Y, my, 1'b0);
                    if (keys) begin
                        add(EV_KEY, CODE_TOOL, KEY_DOWN, 1'b0);
                        add(EV_KEY, CODE_TOUCH, KEY_DOWN, 1'b0);
                    end
                    add(EV_SYN, CODE_SYNC, 32'd0, 1'b1);
                end
            end
            run_n = expected_q.size() - start_n;
            if (run_n > longest_run) longest_run = run_n;
            if (active_cnt > peak_active) peak_active = active_cnt;
        endfunction

        function void check_event(t_ev got);
            t_ev want;
            events_checked++;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("Event %0d unexpected: type %0d code %0d value %0d last %0b",
                             events_checked, got.ev_type, got.ev_code,
                             $signed(got.ev_value), got.last);
                return;
            end
            want = expected_q.pop_front();
            if (got.ev_type !== want.ev_type || got.ev_code !== want.ev_code ||
                got.ev_value !== want.ev_value || got.last !== want.last) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("Event %0d mismatch: expected %0d/%0d/%0d/%0b, got %0d/%0d/%0d/%0b",
                             events_checked, want.ev_type, want.ev_code,
                             $signed(want.ev_value), want.last, got.ev_type, got.ev_code,
                             $signed(got.ev_value), got.last);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    int   cycle_count = 0;
    int   settings_used = 0;
    int   rx_cycle = 0;
    int   rx_hold = 0;
    t_rx_mode rx_mode = RX_OPEN;
    t_slot_event_board board = new();

    mtse_in_if  touch_ch ();
    mtse_cfg_if cfg_ch ();
    mtse_ev_if  event_ch ();

    multitouch_slot_event_encoder_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_touch (touch_ch),
        .i_cfg   (cfg_ch),
        .o_event (event_ch)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    always @(negedge i_clk) begin
        if (rx_cycle % 160 == 0) rx_mode = t_rx_mode'($urandom_range(0, 3));
        rx_cycle++;
        case (rx_mode)
            RX_OPEN:     event_ch.ready = 1'b1;
            RX_RANDOM:   event_ch.ready = ($urandom_range(0, 9) >= 4);
            RX_PERIODIC: event_ch.ready = ((rx_cycle % 7) >= 3);
            default: begin
                if (rx_hold > 0) begin
                    rx_hold--;
                    event_ch.ready = 1'b0;
                end else if ($urandom_range(0, 15) == 0) begin
                    rx_hold = $urandom_range(4, 19);
                    event_ch.ready = 1'b0;
                end else begin
                    event_ch.ready = 1'b1;
                end
            end
        endcase
    end

    always @(posedge i_clk) begin
        t_ev seen;
        cycle_count++;
        if (event_ch.valid === 1'b1 && event_ch.ready === 1'b1) begin
            seen.ev_type  = event_ch.ev_type;
            seen.ev_code  = event_ch.ev_code;
            seen.ev_value = event_ch.ev_value;
            seen.last     = event_ch.last;
            board.check_event(seen);
        end
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles, %0d events outstanding",
                     cycle_count, board.pending());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic t_touch make_touch(input logic cmd, input int slot,
                                          input logic [1:0] action,
                                          input int x, input int y);
        t_touch t;
        t.cmd    = cmd;
        t.slot   = SLOT_W'(slot);
        t.action = action;
        t.pos_x  = POS_W'(x);
        t.pos_y  = POS_W'(y);
        return t;
    endfunction

    function automatic logic signed [POS_W-1:0] random_pos();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 11) return POS_W'($urandom_range(0, 1000));
        if (pick < 14) begin
            case ($urandom_range(0, 5))
                0: return 16'h8000;
                1: return 16'h7FFF;
                2: return 16'hFFFF;
                3: return 16'h0000;
                4: return 16'd1000;
                default: return 16'd1001;
            endcase
        end
        return POS_W'($urandom);
    endfunction

    function automatic logic signed [POS_W-1:0] random_bound(input bit upper);
        if ($urandom_range(0, 3) == 0) return POS_W'($urandom);
        if (upper) return POS_W'($urandom_range(1001, 32767));
        return POS_W'(int'($urandom_range(0, 3000)) - 1500);
    endfunction

    task automatic send_touch(input t_touch t);
        @(negedge i_clk);
        touch_ch.valid  = 1'b1;
        touch_ch.cmd    = t.cmd;
        touch_ch.slot   = t.slot;
        touch_ch.action = t.action;
        touch_ch.pos_x  = t.pos_x;
        touch_ch.pos_y  = t.pos_y;
        @(posedge i_clk);
        while (touch_ch.ready !== 1'b1) @(posedge i_clk);
        board.note_touch(t);
    endtask

    task automatic idle_touch(input int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            touch_ch.valid = 1'b0;
        end
    endtask

    task automatic wait_drained(input int settle);
        idle_touch(1);
        while (board.pending() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = data;
        @(posedge i_clk);
        while (cfg_ch.ready !== 1'b1) @(posedge i_clk);
        board.write_reg(idx, data);
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic load_setting(input int xl, input int xh, input int yl, input int yh,
                                input int mx, input int my);
        settings_used++;
        write_reg(REG_X_LOW, CFG_DATA_W'(xl));
        write_reg(REG_X_HIGH, CFG_DATA_W'(xh));
        write_reg(REG_Y_LOW, CFG_DATA_W'(yl));
        write_reg(REG_Y_HIGH, CFG_DATA_W'(yh));
        write_reg(REG_MIRROR_X, CFG_DATA_W'(mx));
        write_reg(REG_MIRROR_Y, CFG_DATA_W'(my));
    endtask

    // mostly well-formed touch traffic on valid slots, plus drops and release-all
    task automatic run_phase(input int count, input int down_pct, input bit hold_mid);
        t_touch t;
        int     k, burst_left, pick;
        burst_left = 0;
        for (k = 0; k < count; k++) begin
            if (hold_mid && k == count / 2) begin
                wait_drained(0);
                burst_left = 0;
            end
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 12);
                if ($urandom_range(0, 3) != 0) idle_touch($urandom_range(1, 8));
            end
            burst_left--;
            pick     = $urandom_range(0, 99);
            t.cmd    = CMD_POINT;
            t.slot   = SLOT_W'($urandom_range(0, SLOT_COUNT - 1));
            t.action = ACT_MOVE;
            t.pos_x  = random_pos();
            t.pos_y  = random_pos();
            if (pick < 3) begin
                t.cmd    = CMD_RELEASE;
                t.slot   = SLOT_W'($urandom);
                t.action = 2'($urandom);
            end else if (pick < 7) begin
                t.slot   = SLOT_W'($urandom_range(SLOT_COUNT, 15));
                t.action = 2'($urandom);
            end else if (pick < 10) begin
                t.action = ACT_NONE;
            end else if (pick < 10 + down_pct) begin
                t.action = ACT_DOWN;
            end else if ($urandom_range(0, 9) < 6) begin
                t.action = ACT_MOVE;
            end else begin
                t.action = ACT_UP;
            end
            send_touch(t);
        end
    endtask

    initial begin
        int s;
        i_rst_n         = 1'b0;
        touch_ch.valid  = 1'b0;
        touch_ch.cmd    = CMD_POINT;
        touch_ch.slot   = '0;
        touch_ch.action = ACT_DOWN;
        touch_ch.pos_x  = '0;
        touch_ch.pos_y  = '0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = REG_X_LOW;
        cfg_ch.data     = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // drops and no-op cases first, then first down, repeated down, clamps, idle move
        send_touch(make_touch(CMD_RELEASE, 0, ACT_DOWN, 0, 0));
        send_touch(make_touch(CMD_POINT, 0, ACT_UP, 0, 0));
        send_touch(make_touch(CMD_POINT, 1, ACT_NONE, 10, 10));
        send_touch(make_touch(CMD_POINT, SLOT_COUNT, ACT_DOWN, 10, 10));
        send_touch(make_touch(CMD_POINT, 15, ACT_DOWN, -1, -1));
        send_touch(make_touch(CMD_POINT, 0, ACT_DOWN, 0, 0));
        send_touch(make_touch(CMD_POINT, 9, ACT_DOWN, 1000, 1000));
        send_touch(make_touch(CMD_POINT, 0, ACT_DOWN, 500, -1));
        send_touch(make_touch(CMD_POINT, 9, ACT_MOVE, 32767, -32768));
        send_touch(make_touch(CMD_POINT, 3, ACT_MOVE, 1001, 4095));
        send_touch(make_touch(CMD_POINT, 0, ACT_UP, 0, 0));
        send_touch(make_touch(CMD_POINT, 9, ACT_UP, 0, 0));
        send_touch(make_touch(CMD_POINT, 3, ACT_UP, 0, 0));
        wait_drained(SETTLE_CYCLES);

        load_setting(-32768, 32767, 0, 500, 1, 1);
        write_reg(REG_SPARE_LO, 16'hFFFF);
        write_reg(REG_SPARE_HI, 16'h5A5A);
        send_touch(make_touch(CMD_POINT, 5, ACT_DOWN, 0, 1000));
        send_touch(make_touch(CMD_POINT, 5, ACT_MOVE, 1000, -32768));
        for (s = 0; s < SLOT_COUNT; s++)
            send_touch(make_touch(CMD_POINT, s, ACT_DOWN, random_pos(), random_pos()));
        send_touch(make_touch(CMD_RELEASE, 0, ACT_NONE, 0, 0));
        wait_drained(SETTLE_CYCLES);

        load_setting(0, 4095, 0, 4095, 0, 0);
        run_phase(PHASE_ITEMS, 35, 1'b0);
        wait_drained(SETTLE_CYCLES);
        load_setting(-32768, 32767, 100, 100, 1, 1);
        run_phase(PHASE_ITEMS, 50, 1'b0);
        wait_drained(SETTLE_CYCLES);
        load_setting(0, 800, -500, 2000, 1, 0);
        run_phase(PHASE_ITEMS, 30, 1'b1);
        wait_drained(SETTLE_CYCLES);
        load_setting(random_bound(1'b0), random_bound(1'b1),
                     random_bound(1'b0), random_bound(1'b1),
                     $urandom_range(0, 1), $urandom_range(0, 1));
        run_phase(PHASE_ITEMS, 40, 1'b0);
        wait_drained(SETTLE_CYCLES);
        load_setting(32767, -32768, -32768, -32767, 0, 1);
        run_phase(PHASE_ITEMS, 55, 1'b0);
        wait_drained(SETTLE_CYCLES);
        load_setting(random_bound(1'b0), random_bound(1'b1),
                     random_bound(1'b0), random_bound(1'b1),
                     $urandom_range(0, 1), $urandom_range(0, 1));
        run_phase(PHASE_ITEMS, 35, 1'b0);
        wait_drained(SETTLE_CYCLES);

        $display("Ran %0d touch items under %0d axis settings; %0d events checked, %0d bad",
                 board.items_noted, settings_used, board.events_checked, board.mismatches);
        $display("Up to %0d slots held at once; longest event run %0d events",
                 board.peak_active, board.longest_run);
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

[filelist.f]
rtl/mtse_pkg.sv
rtl/mtse_if.sv
rtl/mtse_front.sv
rtl/mtse_queue.sv
rtl/mtse_back.sv
rtl/multitouch_slot_event_encoder_unit.sv
bench/testbench.sv
